// ----- hw/rtl/tmacg_pkg.sv -----
`default_nettype none
package tmacg_pkg;

	// input transaction: one font write, text byte or scan tick
	typedef struct packed {
		logic [1:0]  action;
		logic [11:0] font_address;
		logic [7:0]  font_data;
		logic [7:0]  text_byte;
	} in_item_t;

	// output transaction: one pixel group
	typedef struct packed {
		logic [6:0] pixels;
		logic [6:0] column;
		logic [3:0] glyph_line;
		logic       end_of_line;
		logic       end_of_row;
	} out_item_t;

	// configuration write
	typedef struct packed {
		logic [1:0] index;
		logic [6:0] value;
	} cfg_item_t;

	typedef enum logic [1:0] {
		ACT_FONT_WRITE = 2'd0,
		ACT_TEXT_BYTE  = 2'd1,
		ACT_SCAN_TICK  = 2'd2,
		ACT_NONE       = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CFG_CURSOR_COLUMN       = 2'd0,
		CFG_CURSOR_ROW          = 2'd1,
		CFG_CURSOR_IS_UNDERLINE = 2'd2,
		CFG_UNDERLINE_GLYPH_ROW = 2'd3
	} cfg_index_t;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int LINE_W = 4;
	localparam int PIX_W  = 7;

	localparam logic [7:0] SPECIAL_MASK      = 8'hF0;
	localparam logic [7:0] CODE_BLANK_ROW    = 8'hF0;
	localparam logic [7:0] CODE_BLANK_SCREEN = 8'hF2;
	localparam logic [6:0] PIX_ALL           = 7'h7F;

	localparam logic [6:0] CURSOR_COLUMN_RST = 7'd127;
	localparam logic [4:0] CURSOR_ROW_RST    = 5'd31;
	localparam logic [3:0] UNDERLINE_ROW_RST = 4'd10;

	localparam int OUT_DEPTH = 4;

	// field mode: bit 4 underline, bit 3 reverse, bit 2 semigraphic font
	typedef struct packed {
		logic       underline;
		logic       reverse;
		logic       font;
		logic [1:0] other;
	} mode_t;

	typedef struct packed {
		logic       visible;
		logic       font;
		logic [6:0] code;
		logic       underline;
		logic       reverse;
	} cell_t;

	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic [LINE_W-1:0] glyph_line;
		logic              end_of_line;
		logic              end_of_row;
	} scan_meta_t;

	typedef struct packed {
		logic [COL_W-1:0] cursor_column;
		logic [ROW_W-1:0] cursor_row;
		logic             cursor_is_underline;
		logic [3:0]       underline_glyph_row;
	} cfg_regs_t;

	// stage 1 -> stage 2 control
	typedef struct packed {
		logic       valid;
		scan_meta_t meta;
	} scan_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tmacg_stream_if.sv -----
`default_nettype none
interface tmacg_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/text_mode_attribute_character_generator_unit.sv -----
`default_nettype none
// Text-mode character generator with field attributes. One input transaction
// per clock unless item is stalled: a font write fills the 4096-byte glyph
// memory (two 128-glyph fonts, 16 rows each), a text byte is decoded (mode
// codes, row and screen blanking, cursor) into the row memory of COLUMNS
// cells, and a scan tick reads the next cell and its glyph row and yields one
// 7-pixel group with underline and reverse applied. Scan ticks walk
// GLYPH_LINES lines of COLUMNS columns. A pixel group passes the registered
// row memory read, the registered glyph memory read and the 4-entry output
// queue in that order. The item channel only stalls when that queue plus the
// groups in flight would exceed its four entries, i.e. when the result sink
// holds off. Memories need no clearing after reset.
// Configuration writes are always ready and should only be issued while idle.
module text_mode_attribute_character_generator_unit #(
	parameter int COLUMNS     = 80,
	parameter int ROWS        = 25,
	parameter int GLYPH_LINES = 11
) (
	input  logic           clk,
	input  logic           arst_n,
	tmacg_stream_if.sink   item,
	tmacg_stream_if.source result,
	tmacg_stream_if.sink   cfg
);
	import tmacg_pkg::*;

	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	in_item_t  item_data;
	cfg_item_t cfg_data;
	cfg_regs_t cfg_regs_q;

	logic item_acc, font_acc, text_acc, scan_acc;
	logic cfg_acc;

	scan_ctl_t ctl_s1;
	cell_t     cell_s1;
	logic      valid_s2;
	out_item_t group_s2;

	logic             q_not_empty;
	out_item_t        q_head;
	logic [CNT_W-1:0] q_count;
	logic [CNT_W:0]   occupancy;
	logic             res_acc;

	assign item_data = item.data;
	assign cfg_data  = cfg.data;

	// slots taken: queued groups plus groups still in the memory pipeline
	assign occupancy  = {1'b0, q_count} + (CNT_W + 1)'(ctl_s1.valid)
		+ (CNT_W + 1)'(valid_s2);
	assign item.ready = (occupancy < (CNT_W + 1)'(OUT_DEPTH));
	assign item_acc   = item.valid && item.ready;
	assign font_acc   = item_acc && (item_data.action == ACT_FONT_WRITE);
	assign text_acc   = item_acc && (item_data.action == ACT_TEXT_BYTE);
	assign scan_acc   = item_acc && (item_data.action == ACT_SCAN_TICK);

	// configuration registers
	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q.cursor_column       <= CURSOR_COLUMN_RST;
			cfg_regs_q.cursor_row          <= CURSOR_ROW_RST;
			cfg_regs_q.cursor_is_underline <= 1'b0;
			cfg_regs_q.underline_glyph_row <= UNDERLINE_ROW_RST;
		end else if (cfg_acc) begin
			case (cfg_index_t'(cfg_data.index))
				CFG_CURSOR_COLUMN:
					cfg_regs_q.cursor_column <= cfg_data.value;
				CFG_CURSOR_ROW:
					cfg_regs_q.cursor_row <= cfg_data.value[ROW_W-1:0];
				CFG_CURSOR_IS_UNDERLINE:
					cfg_regs_q.cursor_is_underline <= cfg_data.value[0];
				CFG_UNDERLINE_GLYPH_ROW:
					cfg_regs_q.underline_glyph_row <= cfg_data.value[3:0];
				default:
					cfg_regs_q <= cfg_regs_q;
			endcase
		end
	end

	// text decode, row memory and scan position
	tmacg_row_store #(
		.COLUMNS     (COLUMNS),
		.ROWS        (ROWS),
		.GLYPH_LINES (GLYPH_LINES)
	) u_row_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_acc  (text_acc),
		.scan_acc  (scan_acc),
		.text_byte (item_data.text_byte),
		.cfg_regs  (cfg_regs_q),
		.ctl_s1    (ctl_s1),
		.cell_s1   (cell_s1)
	);

	// glyph memory and pixel attributes
	tmacg_glyph_store u_glyph_store (
		.clk                 (clk),
		.arst_n              (arst_n),
		.font_acc            (font_acc),
		.font_address        (item_data.font_address),
		.font_data           (item_data.font_data),
		.underline_glyph_row (cfg_regs_q.underline_glyph_row),
		.ctl_s1              (ctl_s1),
		.cell_s1             (cell_s1),
		.valid_s2            (valid_s2),
		.group_s2            (group_s2)
	);

	// output queue decouples the sink from the pipeline
	tmacg_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s2),
		.push_data (group_s2),
		.pop       (res_acc),
		.not_empty (q_not_empty),
		.head      (q_head),
		.count     (q_count)
	);

	assign result.valid = q_not_empty;
	assign result.data  = q_head;
	assign res_acc      = result.valid && result.ready;

	// queue never overflows: in-flight groups always have a reserved slot
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= (CNT_W + 1)'(OUT_DEPTH))
		else $error("output queue overcommitted");

	// a scan tick reaches the glyph read stage in the next cycle
	a_scan_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		scan_acc |=> ctl_s1.valid)
		else $error("scan tick lost before glyph read");

	// glyph read stage never stalls
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid |=> valid_s2)
		else $error("pipeline stage dropped a group");

	// a full queue receives a group only while it is popped in the same cycle
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (q_count < CNT_W'(OUT_DEPTH)) || res_acc)
		else $error("group pushed into full queue");

	// end of row only on the last column
	a_eor_eol: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.end_of_row |-> result.data.end_of_line)
		else $error("end of row without end of line");

endmodule
`default_nettype wire

// ----- hw/rtl/tmacg_row_store.sv -----
`default_nettype none
module tmacg_row_store #(
	parameter int COLUMNS     = 80,
	parameter int ROWS        = 25,
	parameter int GLYPH_LINES = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_acc,
	input  logic                scan_acc,
	input  logic [7:0]          text_byte,
	input  tmacg_pkg::cfg_regs_t cfg_regs,
	output tmacg_pkg::scan_ctl_t ctl_s1,
	output tmacg_pkg::cell_t     cell_s1
);
	import tmacg_pkg::*;

	localparam int CIW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	cell_t row_mem [COLUMNS];

	logic [COL_W-1:0]  text_column_q;
	logic [ROW_W-1:0]  text_row_q;
	mode_t             mode_q;
	logic              blank_row_q;
	logic              blank_screen_q;
	logic [COL_W-1:0]  scan_column_q;
	logic [LINE_W-1:0] scan_line_q;

	scan_meta_t meta_s1;
	logic       valid_s1;

	logic  col_zero, screen_start, cursor_hit, text_last_col, text_last_row;
	logic  blank_screen_eff, blank_row_eff;
	mode_t mode_eff, mode_n;
	logic  blank_screen_n, blank_row_n;
	cell_t cell_w;
	logic  scan_eol, scan_eor;

	assign ctl_s1 = '{valid: valid_s1, meta: meta_s1};

	always_comb begin
		col_zero         = (text_column_q == '0);
		screen_start     = col_zero && (text_row_q == '0);
		mode_eff         = screen_start ? mode_t'('0) : mode_q;
		blank_screen_eff = screen_start ? 1'b0 : blank_screen_q;
		blank_row_eff    = col_zero ? blank_screen_eff : blank_row_q;
		cursor_hit       = (text_column_q == cfg_regs.cursor_column)
			&& (text_row_q == cfg_regs.cursor_row);
		mode_n           = mode_eff;
		blank_screen_n   = blank_screen_eff;
		blank_row_n      = blank_row_eff;
		cell_w           = '0;
		if (text_byte[7]) begin
			if ((text_byte & SPECIAL_MASK) == SPECIAL_MASK) begin
				if (text_byte == CODE_BLANK_ROW) begin
					blank_row_n = 1'b1;
				end else if (text_byte == CODE_BLANK_SCREEN) begin
					blank_screen_n = 1'b1;
				end
			end else begin
				mode_n = '{underline: text_byte[5], reverse: text_byte[4],
					font: text_byte[2], other: text_byte[1:0]};
			end
		end else if (!blank_row_eff) begin
			cell_w.visible   = 1'b1;
			cell_w.font      = mode_eff.font;
			cell_w.code      = text_byte[6:0];
			cell_w.underline = mode_eff.underline
				^ (cursor_hit && cfg_regs.cursor_is_underline);
			cell_w.reverse   = mode_eff.reverse
				^ (cursor_hit && !cfg_regs.cursor_is_underline);
		end
		text_last_col = (text_column_q == COL_W'(COLUMNS - 1));
		text_last_row = (text_row_q == ROW_W'(ROWS - 1));
		scan_eol      = (scan_column_q == COL_W'(COLUMNS - 1));
		scan_eor      = scan_eol && (scan_line_q == LINE_W'(GLYPH_LINES - 1));
	end

	// row memory: text writes and scan reads, one per cycle
	always_ff @(posedge clk) begin
		if (text_acc) begin
			row_mem[text_column_q[CIW-1:0]] <= cell_w;
		end
		if (scan_acc) begin
			cell_s1 <= row_mem[scan_column_q[CIW-1:0]];
			meta_s1 <= '{column: scan_column_q, glyph_line: scan_line_q,
				end_of_line: scan_eol, end_of_row: scan_eor};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_column_q  <= '0;
			text_row_q     <= '0;
			mode_q         <= '0;
			blank_row_q    <= 1'b0;
			blank_screen_q <= 1'b0;
			scan_column_q  <= '0;
			scan_line_q    <= '0;
			valid_s1       <= 1'b0;
		end else begin
			valid_s1 <= scan_acc;
			if (text_acc) begin
				mode_q         <= mode_n;
				blank_row_q    <= blank_row_n;
				blank_screen_q <= blank_screen_n;
				if (text_last_col) begin
					text_column_q <= '0;
					text_row_q    <= text_last_row ? '0 : text_row_q + 1'b1;
				end else begin
					text_column_q <= text_column_q + 1'b1;
				end
			end
			if (scan_acc) begin
				if (scan_eol) begin
					scan_column_q <= '0;
					scan_line_q   <= scan_eor ? '0 : scan_line_q + 1'b1;
				end else begin
					scan_column_q <= scan_column_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tmacg_glyph_store.sv -----
`default_nettype none
module tmacg_glyph_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 font_acc,
	input  logic [11:0]          font_address,
	input  logic [7:0]           font_data,
	input  logic [3:0]           underline_glyph_row,
	input  tmacg_pkg::scan_ctl_t ctl_s1,
	input  tmacg_pkg::cell_t     cell_s1,
	output logic                 valid_s2,
	output tmacg_pkg::out_item_t group_s2
);
	import tmacg_pkg::*;

	logic [7:0] font_mem [4096];

	logic [7:0] glyph_s2;
	logic       visible_s2, underline_s2, reverse_s2;
	scan_meta_t meta_s2;
	logic [PIX_W-1:0] pix;

	// glyph memory: a write in the same cycle as a read returns the old byte,
	// which matches transaction order since the write came later
	always_ff @(posedge clk) begin
		if (font_acc) begin
			font_mem[font_address] <= font_data;
		end
		if (ctl_s1.valid) begin
			glyph_s2     <= font_mem[{cell_s1.font, cell_s1.code, ctl_s1.meta.glyph_line}];
			visible_s2   <= cell_s1.visible;
			underline_s2 <= cell_s1.underline;
			reverse_s2   <= cell_s1.reverse;
			meta_s2      <= ctl_s1.meta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= ctl_s1.valid;
		end
	end

	always_comb begin
		pix = glyph_s2[PIX_W-1:0];
		if (underline_s2 && (meta_s2.glyph_line == underline_glyph_row)) begin
			pix = PIX_ALL;
		end
		if (reverse_s2) begin
			pix = pix ^ PIX_ALL;
		end
		if (!visible_s2) begin
			pix = '0;
		end
		group_s2.pixels      = pix;
		group_s2.column      = meta_s2.column;
		group_s2.glyph_line  = meta_s2.glyph_line;
		group_s2.end_of_line = meta_s2.end_of_line;
		group_s2.end_of_row  = meta_s2.end_of_row;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tmacg_out_fifo.sv -----
`default_nettype none
module tmacg_out_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tmacg_pkg::out_item_t push_data,
	input  logic                 pop,
	output logic                 not_empty,
	output tmacg_pkg::out_item_t head,
	output logic [$clog2(tmacg_pkg::OUT_DEPTH+1)-1:0] count
);
	import tmacg_pkg::*;

	localparam int PW = $clog2(OUT_DEPTH);

	out_item_t        slot_q [OUT_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;

	assign not_empty = (count != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count <= count + 1'b1;
				2'b01:   count <= count - 1'b1;
				default: count <= count;
			endcase
		end
	end

endmodule
`default_nettype wire
